### hw/rtl/wwalu_pkg.sv
// Package for the wide-word ALU: operation codes, widths and pipeline stage types.
`default_nettype none

package wwalu_pkg;

  localparam int WORD_W   = 64;
  localparam int NWORDS   = 4;
  localparam int VALUE_W  = WORD_W * NWORDS;
  localparam int LIMB_W   = 32;
  localparam int HLIMB_W  = 16;
  localparam int HWORD_W  = 128;
  localparam int AMOUNT_W = 9;
  localparam int FINE_W   = 6;
  localparam int MODE_W   = 4;
  localparam int ORDER_W  = 2;
  localparam int IN_DATA_W  = 528;
  localparam int OUT_DATA_W = 264;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD         = 4'd0,
    MODE_SUB         = 4'd1,
    MODE_CMP         = 4'd2,
    MODE_AND         = 4'd3,
    MODE_OR          = 4'd4,
    MODE_XOR         = 4'd5,
    MODE_NOT         = 4'd6,
    MODE_SHL         = 4'd7,
    MODE_SHR         = 4'd8,
    MODE_GETLIMB     = 4'd9,
    MODE_SETLIMB     = 4'd10,
    MODE_SETHALFLIMB = 4'd11,
    MODE_SETHALFWORD = 4'd12
  } mode_t;

  localparam logic [ORDER_W-1:0] ORDER_LESS    = 2'b11;
  localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'b00;
  localparam logic [ORDER_W-1:0] ORDER_GREATER = 2'b01;

  // First stage: per-word sums for both carry-in values, per-word compares,
  // word-granular shift and the results of the simple operations.
  typedef struct packed {
    mode_t                         mode;
    logic                          cin;
    logic [NWORDS-1:0][WORD_W:0]   sum0;
    logic [NWORDS-1:0][WORD_W:0]   sum1;
    logic [NWORDS-1:0]             lt;
    logic [NWORDS-1:0]             gt;
    logic [VALUE_W-1:0]            coarse;
    logic [FINE_W-1:0]             fine_amt;
    logic [VALUE_W-1:0]            misc;
  } s1_t;

  // Second stage: resolved sum, bit-granular shift and compare outcome.
  typedef struct packed {
    mode_t               mode;
    logic [VALUE_W-1:0]  sum;
    logic                carry;
    logic [VALUE_W-1:0]  shifted;
    logic [ORDER_W-1:0]  order;
    logic [VALUE_W-1:0]  misc;
  } s2_t;

endpackage

`default_nettype wire

### hw/rtl/wide_word_alu_256.sv
// Top level of the 256-bit wide-word ALU: three-stage pipeline with stream handshakes.
`default_nettype none

// wide_word_alu_256 performs one 256-bit operation per input transaction and
// returns exactly one result transaction for it, in order. The operation code
// travels in in_tuser; the operands, carry-in and amount travel in in_tdata.
// A new transaction can be accepted in every clock cycle as long as the results are
// taken. Its result passes through the stage 1, stage 2 and output registers
// before it shows on out_tvalid. There are three register stages: the first
// forms per-word sums for both carry values, word compares, the word-granular
// part of the shifts and the bitwise, limb extract and insert results; the
// second resolves the carry chain across the four words, finishes the shift
// within a word and folds the compares; the third selects the result by
// operation into the output register. Each stage advances when the stage after
// it is empty or being emptied, so a stalled output holds its result while
// earlier stages keep filling, and nothing is dropped or repeated. Subtract
// returns a borrow in carry_out, compare returns -1, 0 or 1 in order, shifts of
// 256 or more give zero, and operation codes 13 to 15 return an all-zero result.
module wide_word_alu_256 (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output      logic                            in_tready,
  // a_word0..a_word3 [255:0], b_word0..b_word3 [511:256], carry [512],
  // amount [521:513], zero fill [527:522]
  input  wire logic [wwalu_pkg::IN_DATA_W-1:0] in_tdata,
  // mode [3:0]
  input  wire logic [wwalu_pkg::MODE_W-1:0]    in_tuser,
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  // r_word0..r_word3 [255:0], carry_out [256], order [258:257],
  // zero fill [263:259]
  output      logic [wwalu_pkg::OUT_DATA_W-1:0] out_tdata
);
  import wwalu_pkg::*;

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  logic [OUT_DATA_W-1:0] out_r, out_nxt;

  // Each stage may load when it is empty or its content moves on.
  assign rdy3      = !v3_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  // ---------------------------------------------------------------- stage 1
  logic [VALUE_W-1:0]  in_a, in_b, b_sel;
  logic                in_cin;
  logic [AMOUNT_W-1:0] in_amt;
  mode_t               in_mode;

  assign in_a    = in_tdata[VALUE_W-1:0];
  assign in_b    = in_tdata[2*VALUE_W-1:VALUE_W];
  assign in_cin  = in_tdata[2*VALUE_W];
  assign in_amt  = in_tdata[2*VALUE_W+AMOUNT_W:2*VALUE_W+1];
  assign in_mode = mode_t'(in_tuser);

  // Subtraction is a + ~b + (1 - borrow).
  assign b_sel = (in_mode == MODE_SUB) ? ~in_b : in_b;

  always_comb begin
    logic [WORD_W-1:0] aw, bw, bsw;
    logic [7:0]        coarse_amt;
    s1_nxt          = '0;
    s1_nxt.mode     = in_mode;
    s1_nxt.cin      = (in_mode == MODE_SUB) ? !in_cin : in_cin;
    s1_nxt.fine_amt = in_amt[FINE_W-1:0];
    for (int i = 0; i < NWORDS; i++) begin
      aw  = in_a[i*WORD_W +: WORD_W];
      bw  = in_b[i*WORD_W +: WORD_W];
      bsw = b_sel[i*WORD_W +: WORD_W];
      s1_nxt.sum0[i] = {1'b0, aw} + {1'b0, bsw};
      s1_nxt.sum1[i] = {1'b0, aw} + {1'b0, bsw} + {{WORD_W{1'b0}}, 1'b1};
      s1_nxt.lt[i]   = aw < bw;
      s1_nxt.gt[i]   = aw > bw;
    end
    // Whole-word part of the shift; amounts of 256 or more clear the value.
    coarse_amt = {in_amt[7:6], 6'd0};
    if (in_amt[8]) begin
      s1_nxt.coarse = '0;
    end else if (in_mode == MODE_SHL) begin
      s1_nxt.coarse = in_a << coarse_amt;
    end else begin
      s1_nxt.coarse = in_a >> coarse_amt;
    end
    case (in_mode)
      MODE_AND: begin
        s1_nxt.misc = in_a & in_b;
      end
      MODE_OR: begin
        s1_nxt.misc = in_a | in_b;
      end
      MODE_XOR: begin
        s1_nxt.misc = in_a ^ in_b;
      end
      MODE_NOT: begin
        s1_nxt.misc = ~in_a;
      end
      MODE_GETLIMB: begin
        s1_nxt.misc[LIMB_W-1:0] = in_a[{in_amt[2:0], 5'd0} +: LIMB_W];
      end
      MODE_SETLIMB: begin
        s1_nxt.misc = in_a;
        s1_nxt.misc[{in_amt[2:0], 5'd0} +: LIMB_W] = in_b[LIMB_W-1:0];
      end
      MODE_SETHALFLIMB: begin
        s1_nxt.misc = in_a;
        s1_nxt.misc[{in_amt[3:0], 4'd0} +: HLIMB_W] = in_b[HLIMB_W-1:0];
      end
      MODE_SETHALFWORD: begin
        s1_nxt.misc = in_a;
        s1_nxt.misc[{in_amt[0], 7'd0} +: HWORD_W] = in_b[HWORD_W-1:0];
      end
      default: begin
        s1_nxt.misc = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------- stage 2
  always_comb begin
    logic c;
    logic found;
    s2_nxt      = '0;
    s2_nxt.mode = s1_r.mode;
    s2_nxt.misc = s1_r.misc;
    // Carry select across the words: pick the precomputed sum per word.
    c = s1_r.cin;
    for (int i = 0; i < NWORDS; i++) begin
      s2_nxt.sum[i*WORD_W +: WORD_W] = c ? s1_r.sum1[i][WORD_W-1:0]
                                         : s1_r.sum0[i][WORD_W-1:0];
      c = c ? s1_r.sum1[i][WORD_W] : s1_r.sum0[i][WORD_W];
    end
    s2_nxt.carry = (s1_r.mode == MODE_SUB) ? !c : c;
    if (s1_r.mode == MODE_SHL) begin
      s2_nxt.shifted = s1_r.coarse << s1_r.fine_amt;
    end else begin
      s2_nxt.shifted = s1_r.coarse >> s1_r.fine_amt;
    end
    // The most significant differing word decides the order.
    found        = 1'b0;
    s2_nxt.order = ORDER_EQUAL;
    for (int i = NWORDS - 1; i >= 0; i--) begin
      if (!found && s1_r.lt[i]) begin
        s2_nxt.order = ORDER_LESS;
        found        = 1'b1;
      end else if (!found && s1_r.gt[i]) begin
        s2_nxt.order = ORDER_GREATER;
        found        = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stage 3
  always_comb begin
    logic [VALUE_W-1:0] r;
    logic               cout;
    logic [ORDER_W-1:0] ord;
    r    = '0;
    cout = 1'b0;
    ord  = ORDER_EQUAL;
    case (s2_r.mode)
      MODE_ADD, MODE_SUB: begin
        r    = s2_r.sum;
        cout = s2_r.carry;
      end
      MODE_CMP: begin
        ord = s2_r.order;
      end
      MODE_SHL, MODE_SHR: begin
        r = s2_r.shifted;
      end
      MODE_AND, MODE_OR, MODE_XOR, MODE_NOT, MODE_GETLIMB, MODE_SETLIMB,
      MODE_SETHALFLIMB, MODE_SETHALFWORD: begin
        r = s2_r.misc;
      end
      default: begin
        r = '0;
      end
    endcase
    out_nxt = {{(OUT_DATA_W-VALUE_W-1-ORDER_W){1'b0}}, ord, cout, r};
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_tvalid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_r <= s1_nxt;
    end
    if (rdy2) begin
      s2_r <= s2_nxt;
    end
    if (rdy3) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = out_r;

  // ---------------------------------------------------------------- checks
  // An empty output stage means the whole pipeline can take a transaction.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v3_r |-> in_tready)
    else $error("input not ready although output stage is empty");

  // A blocked middle stage keeps its transaction.
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !rdy3) |=> v2_r)
    else $error("stage 2 lost a transaction while stalled");

  // The compare code never takes the unused encoding.
  a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (out_r[VALUE_W+ORDER_W:VALUE_W+1] != 2'b10))
    else $error("invalid order encoding");

  // Carry and order come from different operations and never coexist.
  a_carry_order: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && out_r[VALUE_W]) |-> (out_r[VALUE_W+ORDER_W:VALUE_W+1] == ORDER_EQUAL))
    else $error("carry and order both set");

endmodule

`default_nettype wire

### sim/wide_word_alu_256_test.sv
// Self-checking stream testbench for the 256-bit wide-word ALU.
`default_nettype none

module wide_word_alu_256_test;
  import wwalu_pkg::*;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int SETTLE_TICKS = 10;
  localparam int RANDOM_OPS   = 1680;
  // Inside this window of transactions neither side idles or stalls.
  localparam int STEADY_FIRST = 900;
  localparam int STEADY_LAST  = 1150;
  // Codes above the last defined operation; the block must answer them with zero.
  localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = MODE_W'(MODE_SETHALFWORD + 1);
  localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = '1;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [VALUE_W-1:0]  a;
    logic [VALUE_W-1:0]  b;
    logic                cin;
    logic [AMOUNT_W-1:0] amount;
    logic                drain;  // hold this one back until the pipe is empty
  } alu_op_t;

  typedef struct packed {
    logic [VALUE_W-1:0] r;
    logic               carry;
    logic [ORDER_W-1:0] order;
  } alu_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [MODE_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  alu_op_t     pending_ops[$];
  alu_result_t awaited_results[$];
  alu_op_t     op_on_bus;
  int          ops_accepted = 0;
  int          results_seen = 0;
  int          failures = 0;
  int          cycle_count = 0;

  wide_word_alu_256 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // Computes what the ALU must return for one operation, using whole
  // 256-bit arithmetic rather than the word-by-word carry chain.
  function automatic alu_result_t alu_result_of(alu_op_t op);
    alu_result_t res;
    logic [VALUE_W:0] wide;
    int unsigned idx;
    res = '0;
    case (op.mode)
      MODE_ADD: begin
        wide = {1'b0, op.a} + {1'b0, op.b} + op.cin;
        res.r = wide[VALUE_W-1:0];
        res.carry = wide[VALUE_W];
      end
      MODE_SUB: begin
        // A negative difference wraps, which leaves the borrow in the top bit.
        wide = {1'b0, op.a} - {1'b0, op.b} - op.cin;
        res.r = wide[VALUE_W-1:0];
        res.carry = wide[VALUE_W];
      end
      MODE_CMP:
        res.order = (op.a < op.b) ? ORDER_LESS :
                    (op.a > op.b) ? ORDER_GREATER : ORDER_EQUAL;
      MODE_AND: res.r = op.a & op.b;
      MODE_OR:  res.r = op.a | op.b;
      MODE_XOR: res.r = op.a ^ op.b;
      MODE_NOT: res.r = ~op.a;
      MODE_SHL: if (op.amount < VALUE_W) res.r = op.a << op.amount;
      MODE_SHR: if (op.amount < VALUE_W) res.r = op.a >> op.amount;
      MODE_GETLIMB: begin
        idx = {29'd0, op.amount[2:0]};
        res.r[LIMB_W-1:0] = op.a[idx*LIMB_W +: LIMB_W];
      end
      MODE_SETLIMB: begin
        idx = {29'd0, op.amount[2:0]};
        res.r = op.a;
        res.r[idx*LIMB_W +: LIMB_W] = op.b[LIMB_W-1:0];
      end
      MODE_SETHALFLIMB: begin
        idx = {28'd0, op.amount[3:0]};
        res.r = op.a;
        res.r[idx*HLIMB_W +: HLIMB_W] = op.b[HLIMB_W-1:0];
      end
      MODE_SETHALFWORD: begin
        idx = {31'd0, op.amount[0]};
        res.r = op.a;
        res.r[idx*HWORD_W +: HWORD_W] = op.b[HWORD_W-1:0];
      end
      default: ;
    endcase
    return res;
  endfunction

  // Operands are mostly random, with a share of all-zero, all-one, single-bit-set
  // and single-bit-clear values so that carries run the full width.
  function automatic logic [VALUE_W-1:0] random_operand();
    logic [VALUE_W-1:0] v;
    for (int i = 0; i < VALUE_W / 32; i++) v[i*32 +: 32] = $urandom;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: v = VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
      3: v = ~(VALUE_W'(1) << $urandom_range(0, VALUE_W - 1));
      default: ;
    endcase
    return v;
  endfunction

  function automatic alu_op_t random_op();
    alu_op_t op;
    op.drain = 1'b0;
    if ($urandom_range(0, 99) < 4)
      op.mode = MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
    else
      op.mode = MODE_W'($urandom_range(MODE_ADD, MODE_SETHALFWORD));
    op.a = random_operand();
    op.b = random_operand();
    // Related operands reach equal compares, long borrow chains and
    // compares that differ in a single bit.
    case ($urandom_range(0, 7))
      0: op.b = op.a;
      1: op.b = ~op.a;
      2: begin
        op.b = op.a;
        op.b[8'($urandom_range(0, VALUE_W - 1))] ^= 1'b1;
      end
      default: ;
    endcase
    op.cin = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: op.amount = AMOUNT_W'($urandom_range(0, 15));
      1: op.amount = AMOUNT_W'($urandom_range(VALUE_W - 8, VALUE_W + 8));
      2: op.amount = AMOUNT_W'(64 * $urandom_range(0, 7)) + AMOUNT_W'($urandom_range(0, 1));
      default: op.amount = AMOUNT_W'($urandom_range(0, (1 << AMOUNT_W) - 1));
    endcase
    return op;
  endfunction

  task automatic queue_op(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] a,
                          input logic [VALUE_W-1:0] b, input logic cin,
                          input logic [AMOUNT_W-1:0] amount);
    alu_op_t op;
    op = '{mode: mode, a: a, b: b, cin: cin, amount: amount, drain: 1'b0};
    pending_ops.push_back(op);
  endtask

  // Sender. The expectation is recorded when a transaction is accepted, and a
  // new one is offered only when the bus is free.
  always @(posedge clk) begin : drive_ops
    logic send;
    logic steady;
    alu_op_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        awaited_results.push_back(alu_result_of(op_on_bus));
        ops_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        steady = ops_accepted >= STEADY_FIRST && ops_accepted < STEADY_LAST;
        send = pending_ops.size() != 0 && (steady || $urandom_range(0, 99) >= 15);
        if (send && pending_ops[0].drain && awaited_results.size() != 0) send = 1'b0;
        if (send) begin
          nxt = pending_ops.pop_front();
          op_on_bus = nxt;
          in_tdata <= IN_DATA_W'({nxt.amount, nxt.cin, nxt.b, nxt.a});
          in_tuser <= nxt.mode;
        end
        in_tvalid <= send;
      end
    end
  end

  // Receiver: checks every accepted result against the oldest expectation.
  always @(posedge clk) begin : check_results
    alu_result_t want;
    alu_result_t got;
    logic steady;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.r = out_tdata[VALUE_W-1:0];
        got.carry = out_tdata[VALUE_W];
        got.order = out_tdata[VALUE_W+ORDER_W:VALUE_W+1];
        if (awaited_results.size() == 0) begin
          $display("%0t: result %0d arrived with none expected, actual %h",
                   $time, results_seen, out_tdata);
          failures++;
        end else begin
          want = awaited_results.pop_front();
          for (int w = 0; w < NWORDS; w++)
            if (got.r[w*WORD_W +: WORD_W] !== want.r[w*WORD_W +: WORD_W]) begin
              $display("%0t: result %0d r_word%0d expected %h actual %h", $time,
                       results_seen, w, want.r[w*WORD_W +: WORD_W],
                       got.r[w*WORD_W +: WORD_W]);
              failures++;
            end
          if (got.carry !== want.carry) begin
            $display("%0t: result %0d carry_out expected %b actual %b",
                     $time, results_seen, want.carry, got.carry);
            failures++;
          end
          if (got.order !== want.order) begin
            $display("%0t: result %0d order expected %b actual %b",
                     $time, results_seen, want.order, got.order);
            failures++;
          end
        end
        results_seen++;
      end
      steady = results_seen >= STEADY_FIRST && results_seen < STEADY_LAST;
      out_tready <= steady || $urandom_range(0, 99) >= 15;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : run
    logic [VALUE_W-1:0] ones;
    logic [VALUE_W-1:0] zero;
    logic [VALUE_W-1:0] low_bit;
    logic [VALUE_W-1:0] top_bit;
    alu_op_t op;
    ones = '1;
    zero = '0;
    low_bit = VALUE_W'(1);
    top_bit = low_bit << (VALUE_W - 1);

    // Carry through all four words, and the borrow that wraps to all ones.
    queue_op(MODE_ADD, ones, ones, 1'b1, '0);
    queue_op(MODE_ADD, ones, zero, 1'b1, '1);
    queue_op(MODE_ADD, zero, zero, 1'b0, '0);
    queue_op(MODE_SUB, zero, zero, 1'b1, '0);
    queue_op(MODE_SUB, zero, ones, 1'b0, '0);
    queue_op(MODE_SUB, ones, ones, 1'b0, '1);
    // Compares deciding in the lowest and in the highest word, and equality.
    queue_op(MODE_CMP, zero, low_bit, 1'b0, '0);
    queue_op(MODE_CMP, top_bit, ones >> 1, 1'b1, '0);
    queue_op(MODE_CMP, ones, ones, 1'b0, '0);
    queue_op(MODE_AND, random_operand(), random_operand(), 1'b1, '0);
    queue_op(MODE_OR, random_operand(), random_operand(), 1'b0, '0);
    queue_op(MODE_XOR, ones, random_operand(), 1'b1, '0);
    queue_op(MODE_NOT, random_operand(), ones, 1'b1, '0);
    // Shifts by nothing, by the most that keeps a bit, and by too much.
    queue_op(MODE_SHL, ones, ones, 1'b1, AMOUNT_W'(VALUE_W - 1));
    queue_op(MODE_SHL, ones, zero, 1'b0, AMOUNT_W'(VALUE_W));
    queue_op(MODE_SHR, ones, zero, 1'b0, '0);
    queue_op(MODE_SHR, ones, zero, 1'b0, '1);
    // Index fields wrap; insert values carry more bits than are used.
    queue_op(MODE_GETLIMB, random_operand(), ones, 1'b0, AMOUNT_W'(15));
    queue_op(MODE_SETLIMB, zero, ones, 1'b0, AMOUNT_W'(13));
    queue_op(MODE_SETHALFLIMB, zero, ones, 1'b1, AMOUNT_W'(15));
    queue_op(MODE_SETHALFLIMB, ones, zero, 1'b0, AMOUNT_W'(22));
    queue_op(MODE_SETHALFWORD, zero, ones, 1'b0, '1);
    queue_op(MODE_SETHALFWORD, ones, random_operand(), 1'b0, '0);
    queue_op(MODE_UNUSED_FIRST, ones, ones, 1'b1, '1);
    queue_op(MODE_UNUSED_LAST, ones, ones, 1'b1, '1);

    for (int n = 0; n < RANDOM_OPS; n++) begin
      op = random_op();
      // Twice the sender waits for an empty pipeline before going on.
      op.drain = (n == 500 || n == 1300);
      pending_ops.push_back(op);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_ops.size() != 0 || in_tvalid || awaited_results.size() != 0);
    repeat (SETTLE_TICKS) @(posedge clk);

    if (failures == 0 && awaited_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
